// ===== hdl/tcc_pkg.sv =====
// shared types, constants and codes for the text console cursor engine
package tcc_pkg;

    localparam int ROWS      = 25;
    localparam int COLS      = 80;
    localparam int TAB_WIDTH = 4;
    localparam int CELLS     = ROWS * COLS;
    localparam int MAW       = $clog2(CELLS);
    localparam int AW        = $clog2(CELLS + 1);
    localparam int PW        = AW + 1;

    localparam logic [15:0] BLANK_CELL = 16'h0F00;
    localparam logic [7:0]  BLANK_ATTR = 8'h0F;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_RIGHT = 8'h10;
    localparam logic [7:0] CH_LEFT  = 8'h11;
    localparam logic [7:0] CH_UP    = 8'h1E;
    localparam logic [7:0] CH_DOWN  = 8'h1F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [PW-1:0] P_CELLS = PW'(CELLS);
    localparam logic [PW-1:0] P_COLS  = PW'(COLS);

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_LOCK  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_SCLR,
        S_ROW,
        S_DISP,
        S_TAB,
        S_BS_RD,
        S_BS_CHK,
        S_LEFT,
        S_LEFT_CHK,
        S_RIGHT_CHK,
        S_DOWN,
        S_DOWN_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } t_cmd_item;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic        scrolled;
    } t_res_item;

    typedef struct packed {
        logic           we;
        logic [MAW-1:0] waddr;
        logic [15:0]    wdata;
        logic           re;
        logic [MAW-1:0] raddr;
    } t_mem_req;

endpackage

// ===== hdl/tcc_screen_mem.sv =====
// screen cell store with one write port and one registered read port
module tcc_screen_mem (
    input  logic               i_clk,
    input  tcc_pkg::t_mem_req  i_req,
    output logic [15:0]        o_rdata
);
    import tcc_pkg::*;

    logic [15:0] r_mem [CELLS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tcc_seq.sv =====
// sequencer that walks the screen store for scrolls, searches and cell access
module tcc_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tcc_pkg::t_cmd_item  i_item,
    input  logic                i_out_ready,
    output logic                o_done,
    output tcc_pkg::t_res_item  o_res,
    output tcc_pkg::t_mem_req   o_mem,
    input  logic [15:0]         i_rdata
);
    import tcc_pkg::*;

    t_state         r_state, n_state;
    logic [1:0]     r_cmd;
    logic [7:0]     r_ch, r_color;
    logic [10:0]    r_idx;
    logic [PW-1:0]  r_cursor, n_cursor;
    logic [PW-1:0]  r_lock, n_lock;
    logic [PW-1:0]  r_rs, n_rs;
    logic [PW-1:0]  r_ptr, n_ptr;
    logic           r_sc, n_sc;
    logic           r_nl, n_nl;
    logic [7:0]     r_rchar, n_rchar;
    logic [7:0]     r_rattr, n_rattr;
    t_mem_req       mem;
    logic           accept;
    logic           needs_row;
    logic           needs_row_in;
    logic [PW-1:0]  idx_w;
    logic [PW-1:0]  cur_m1;
    logic [PW-1:0]  nl_pos;
    logic           rd_nz;

    function automatic logic [MAW-1:0] cur_ptr_m1(input logic [PW-1:0] p);
        logic [PW-1:0] d;
        d = p - PW'(1);
        return d[MAW-1:0];
    endfunction

    assign accept  = (r_state == S_IDLE) && i_valid;
    assign o_ready = (r_state == S_IDLE);
    assign idx_w   = PW'(i_item.cell_index);
    assign cur_m1  = r_cursor - PW'(1);
    assign nl_pos  = r_rs + P_COLS;
    assign rd_nz   = (i_rdata[7:0] != CH_NUL);

    assign needs_row = (r_ch == CH_LF) || (r_ch == CH_BS) || (r_ch == CH_UP)
                    || (r_ch == CH_DOWN) || (r_ch == CH_RIGHT);
    assign needs_row_in = (i_item.char_code == CH_LF) || (i_item.char_code == CH_BS)
                       || (i_item.char_code == CH_UP) || (i_item.char_code == CH_DOWN)
                       || (i_item.char_code == CH_RIGHT);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_ptr == PW'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    unique case (t_cmd'(i_item.cmd))
                        CMD_READ: n_state = S_READ;
                        CMD_LOCK, CMD_WRITE: n_state = S_DONE;
                        CMD_PUT: begin
                            priority if (i_item.char_code == CH_NUL) n_state = S_DONE;
                            else if (r_cursor >= P_CELLS) n_state = S_SCROLL;
                            else if (needs_row_in) n_state = S_ROW;
                            else n_state = S_DISP;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_READ: n_state = S_DONE;
            S_SCROLL: begin
                if (r_ptr == PW'(CELLS - COLS)) n_state = S_SCLR;
            end
            S_SCLR: begin
                if (r_ptr == PW'(CELLS - 1)) begin
                    priority if (r_nl) n_state = S_DONE;
                    else if (needs_row) n_state = S_ROW;
                    else n_state = S_DISP;
                end
            end
            S_ROW: begin
                if (nl_pos > r_cursor) n_state = S_DISP;
            end
            S_DISP: begin
                unique case (r_ch)
                    CH_TAB: n_state = S_TAB;
                    CH_LF: n_state = (nl_pos >= P_CELLS) ? S_SCROLL : S_DONE;
                    CH_BS: begin
                        n_state = (r_cursor > r_lock && r_cursor == r_rs) ? S_BS_RD : S_DONE;
                    end
                    CH_LEFT: n_state = S_LEFT;
                    CH_RIGHT: begin
                        n_state = (r_cursor + PW'(1) < P_CELLS) ? S_RIGHT_CHK : S_DOWN;
                    end
                    CH_DOWN: n_state = S_DOWN;
                    default: n_state = S_DONE;
                endcase
            end
            S_TAB: begin
                if (r_ptr == PW'(TAB_WIDTH - 1)) n_state = S_DONE;
            end
            S_BS_RD: n_state = (r_cursor != '0) ? S_BS_CHK : S_DONE;
            S_BS_CHK: n_state = rd_nz ? S_DONE : S_BS_RD;
            S_LEFT: n_state = (r_cursor <= r_lock) ? S_DONE : S_LEFT_CHK;
            S_LEFT_CHK: n_state = rd_nz ? S_DONE : S_LEFT;
            S_RIGHT_CHK: n_state = rd_nz ? S_DONE : S_DOWN;
            S_DOWN: n_state = (r_cursor + r_ptr < P_CELLS) ? S_DOWN_CHK : S_DONE;
            S_DOWN_CHK: n_state = S_DOWN;
            S_DONE: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and store access
    always_comb begin
        n_cursor = r_cursor;
        n_lock   = r_lock;
        n_rs     = r_rs;
        n_ptr    = r_ptr;
        n_sc     = r_sc;
        n_nl     = r_nl;
        n_rchar  = r_rchar;
        n_rattr  = r_rattr;
        mem      = '{we: 1'b0, waddr: '0, wdata: BLANK_CELL, re: 1'b0, raddr: '0};
        unique case (r_state)
            S_CLR: begin
                mem.we    = 1'b1;
                mem.waddr = r_ptr[MAW-1:0];
                n_ptr     = r_ptr + PW'(1);
            end
            S_IDLE: begin
                n_sc    = 1'b0;
                n_nl    = 1'b0;
                n_rchar = '0;
                n_rattr = '0;
                n_ptr   = '0;
                n_rs    = '0;
                if (accept) begin
                    unique case (t_cmd'(i_item.cmd))
                        CMD_READ: begin
                            mem.re    = 1'b1;
                            mem.raddr = i_item.cell_index[MAW-1:0];
                        end
                        CMD_LOCK: n_lock = (idx_w > P_CELLS) ? P_CELLS : idx_w;
                        CMD_WRITE: begin
                            mem.we    = (idx_w < P_CELLS);
                            mem.waddr = i_item.cell_index[MAW-1:0];
                            mem.wdata = {i_item.color, i_item.char_code};
                        end
                        CMD_PUT: begin
                            if (i_item.char_code != CH_NUL && r_cursor >= P_CELLS) begin
                                n_sc = 1'b1;
                            end
                        end
                        default: n_sc = 1'b0;
                    endcase
                end
            end
            S_READ: begin
                if (PW'(r_idx) < P_CELLS) begin
                    n_rchar = i_rdata[7:0];
                    n_rattr = i_rdata[15:8];
                end
            end
            S_SCROLL: begin
                mem.re    = (r_ptr < PW'(CELLS - COLS));
                mem.raddr = MAW'(r_ptr + P_COLS);
                mem.we    = (r_ptr != '0);
                mem.waddr = cur_ptr_m1(r_ptr);
                mem.wdata = i_rdata;
                n_ptr     = r_ptr + PW'(1);
                if (r_ptr == PW'(CELLS - COLS)) n_ptr = r_ptr;
            end
            S_SCLR: begin
                mem.we    = 1'b1;
                mem.waddr = r_ptr[MAW-1:0];
                n_ptr     = r_ptr + PW'(1);
                if (r_ptr == PW'(CELLS - 1)) begin
                    n_cursor = (r_cursor >= P_COLS) ? r_cursor - P_COLS : '0;
                    n_lock   = (r_lock > P_COLS) ? r_lock - P_COLS : '0;
                    n_rs     = '0;
                    n_ptr    = '0;
                end
            end
            S_ROW: begin
                if (nl_pos <= r_cursor) n_rs = nl_pos;
            end
            S_DISP: begin
                n_ptr = '0;
                unique case (r_ch)
                    CH_TAB: n_ptr = '0;
                    CH_LF: begin
                        if (nl_pos >= P_CELLS) begin
                            n_cursor = P_CELLS;
                            n_sc     = 1'b1;
                            n_nl     = 1'b1;
                        end else begin
                            n_cursor = nl_pos;
                        end
                    end
                    CH_CR: n_ptr = '0;
                    CH_BS: begin
                        if (r_cursor > r_lock) begin
                            n_cursor  = cur_m1;
                            mem.we    = 1'b1;
                            mem.waddr = cur_m1[MAW-1:0];
                        end
                    end
                    CH_LEFT: n_ptr = '0;
                    CH_RIGHT: begin
                        n_ptr     = P_COLS;
                        mem.re    = 1'b1;
                        mem.raddr = r_cursor[MAW-1:0];
                    end
                    CH_UP: begin
                        if (r_cursor >= r_lock + P_COLS) n_cursor = r_rs - P_COLS;
                    end
                    CH_DOWN: n_ptr = P_COLS;
                    default: begin
                        if (r_cursor < P_CELLS) begin
                            mem.we    = 1'b1;
                            mem.waddr = r_cursor[MAW-1:0];
                            mem.wdata = {r_color, r_ch};
                            n_cursor  = r_cursor + PW'(1);
                        end
                    end
                endcase
            end
            S_TAB: begin
                if (r_cursor < P_CELLS) begin
                    mem.we    = 1'b1;
                    mem.waddr = r_cursor[MAW-1:0];
                    mem.wdata = {r_color, CH_SPACE};
                    n_cursor  = r_cursor + PW'(1);
                end
                n_ptr = r_ptr + PW'(1);
            end
            S_BS_RD: begin
                mem.re    = (r_cursor != '0);
                mem.raddr = cur_m1[MAW-1:0];
            end
            S_BS_CHK: begin
                if (!rd_nz) n_cursor = cur_m1;
            end
            S_LEFT: begin
                if (r_cursor <= r_lock) begin
                    n_cursor = r_lock;
                end else begin
                    n_cursor  = cur_m1;
                    mem.re    = 1'b1;
                    mem.raddr = cur_m1[MAW-1:0];
                end
            end
            S_LEFT_CHK: n_ptr = r_ptr;
            S_RIGHT_CHK: begin
                if (rd_nz) n_cursor = r_cursor + PW'(1);
            end
            S_DOWN: begin
                mem.re    = (r_cursor + r_ptr < P_CELLS);
                mem.raddr = MAW'(r_rs + r_ptr);
            end
            S_DOWN_CHK: begin
                if (rd_nz) begin
                    n_cursor = nl_pos;
                    n_rs     = nl_pos;
                end
                n_ptr = r_ptr + P_COLS;
            end
            S_DONE: n_ptr = r_ptr;
            default: n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cursor <= '0;
            r_lock   <= '0;
            r_ptr    <= '0;
            r_sc     <= 1'b0;
            r_nl     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_lock   <= n_lock;
            r_ptr    <= n_ptr;
            r_sc     <= n_sc;
            r_nl     <= n_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_item.cmd;
            r_ch    <= i_item.char_code;
            r_color <= i_item.color;
            r_idx   <= i_item.cell_index;
        end
        r_rs    <= n_rs;
        r_rchar <= n_rchar;
        r_rattr <= n_rattr;
    end

    assign o_mem  = mem;
    assign o_done = (r_state == S_DONE) && i_out_ready;
    assign o_res  = '{cursor_pos: r_cursor[10:0],
                      read_char:  (t_cmd'(r_cmd) == CMD_READ) ? r_rchar : 8'h00,
                      read_attr:  (t_cmd'(r_cmd) == CMD_READ) ? r_rattr : 8'h00,
                      scrolled:   r_sc};

endmodule

// ===== hdl/text_console_cursor_engine.sv =====
// text console: 80x25 cell store, cursor sequencer and result register
// printable and CR pass the display state, read the read state; lock and write go to done
// tab also writes up to TAB_WIDTH spaces; newline, backspace, up, down and right arrows
// first step row by row to find the row start; left, backspace and down searches read
// and then check each cell or row visited; a scroll adds one pass over the store
// after reset the store is cleared to blank cells while commands are stalled
module text_console_cursor_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_stall,
    input  tcc_pkg::t_cmd_item  i_cmd,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output tcc_pkg::t_res_item  o_res
);
    import tcc_pkg::*;

    logic         seq_ready;
    logic         seq_done;
    logic         out_ready;
    t_res_item    seq_res;
    t_mem_req     mem_req;
    logic [15:0]  mem_rdata;
    logic         r_out_valid;
    t_res_item    r_out;

    assign out_ready   = !r_out_valid || !i_res_stall;
    assign o_cmd_stall = !seq_ready;

    tcc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_cmd_valid),
        .o_ready     (seq_ready),
        .i_item      (i_cmd),
        .i_out_ready (out_ready),
        .o_done      (seq_done),
        .o_res       (seq_res),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata)
    );

    tcc_screen_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out <= seq_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== tb/sv/tb_text_console_cursor_engine.sv =====
// testbench for the text console cursor engine: directed table, then random commands
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
    import tcc_pkg::*;

    localparam int N_RANDOM = 600;

    typedef struct packed {
        t_cmd_item   item;
        logic        has_exp;
        t_res_item   exp;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cmd_valid;
    logic      o_cmd_stall;
    t_cmd_item i_cmd;
    logic      o_res_valid;
    logic      i_res_stall;
    t_res_item o_res;

    text_console_cursor_engine dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd_valid(i_cmd_valid),
        .o_cmd_stall(o_cmd_stall),
        .i_cmd(i_cmd),
        .o_res_valid(o_res_valid),
        .i_res_stall(i_res_stall),
        .o_res(o_res)
    );

    // shadow console state
    logic [15:0] scr [CELLS];
    int unsigned cur;
    int unsigned lockp;

    t_res_item pending_results [$];
    int        mismatches;
    int        results_seen;
    int        scrolls_seen;
    bit        quiet;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int unsigned ch_at(int unsigned i);
        return (i < CELLS) ? int'(scr[i][7:0]) : 0;
    endfunction

    function automatic void put_cell(int unsigned i, logic [7:0] ch, logic [7:0] attr);
        if (i < CELLS) scr[i] = {attr, ch};
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLS; i++) scr[i] = scr[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) scr[i] = BLANK_CELL;
        cur = (cur >= COLS) ? cur - COLS : 0;
        lockp = (lockp > COLS) ? lockp - COLS : 0;
    endfunction

    function automatic void cursor_down();
        int unsigned row;
        for (int unsigned j = 1; cur + COLS * j < CELLS; j++) begin
            row = cur - cur % COLS;
            if (ch_at(row + COLS * j) != 0) cur = row + COLS;
        end
    endfunction

    function automatic bit console_put(logic [7:0] c, logic [7:0] attr);
        bit sc;
        sc = 1'b0;
        if (c == CH_NUL) return 1'b0;
        if (cur >= CELLS) begin
            scroll_screen();
            sc = 1'b1;
        end
        if (c == CH_TAB) begin
            for (int k = 0; k < TAB_WIDTH; k++)
                if (cur < CELLS) begin
                    put_cell(cur, CH_SPACE, attr);
                    cur++;
                end
        end else if (c == CH_LF) begin
            cur = cur - cur % COLS + COLS;
            if (cur >= CELLS) begin
                cur = CELLS;
                scroll_screen();
                sc = 1'b1;
            end
        end else if (c == CH_CR) begin
        end else if (c == CH_BS) begin
            if (cur > lockp) begin
                cur--;
                put_cell(cur, CH_NUL, BLANK_ATTR);
                if (cur % COLS == COLS - 1)
                    while (cur > 0 && ch_at(cur - 1) == 0) cur--;
            end
        end else if (c == CH_LEFT) begin
            forever begin
                if (cur <= lockp) begin
                    cur = lockp;
                    break;
                end
                cur--;
                if (ch_at(cur) != 0) break;
            end
        end else if (c == CH_RIGHT && cur + 1 < CELLS && ch_at(cur) != 0) begin
            cur++;
        end else if (c == CH_UP) begin
            if (cur >= lockp + COLS) cur = cur - cur % COLS - COLS;
        end else if (c == CH_DOWN || c == CH_RIGHT) begin
            cursor_down();
        end else if (cur < CELLS) begin
            put_cell(cur, c, attr);
            cur++;
        end
        return sc;
    endfunction

    function automatic t_res_item console_step(t_cmd_item it);
        t_res_item r;
        r = '0;
        case (t_cmd'(it.cmd))
            CMD_PUT: r.scrolled = console_put(it.char_code, it.color);
            CMD_READ: if (it.cell_index < CELLS) begin
                r.read_char = scr[it.cell_index][7:0];
                r.read_attr = scr[it.cell_index][15:8];
            end
            CMD_LOCK: lockp = (it.cell_index > CELLS) ? CELLS : it.cell_index;
            default: put_cell(it.cell_index, it.char_code, it.color);
        endcase
        r.cursor_pos = 11'(cur);
        return r;
    endfunction

    function automatic t_cmd_item mk(t_cmd c, logic [7:0] ch, logic [7:0] attr,
                                     logic [10:0] idx);
        t_cmd_item it;
        it.cmd = c;
        it.char_code = ch;
        it.color = attr;
        it.cell_index = idx;
        return it;
    endfunction

    // random command biased toward ordinary text entry
    function automatic t_cmd_item rand_cmd();
        int unsigned p;
        logic [7:0] ch;
        p = $urandom_range(0, 99);
        if (p < 40) ch = 8'($urandom_range(8'h21, 8'h7E));
        else if (p < 48) ch = CH_LF;
        else if (p < 52) ch = CH_TAB;
        else if (p < 58) ch = CH_BS;
        else if (p < 62) ch = CH_LEFT;
        else if (p < 66) ch = CH_RIGHT;
        else if (p < 69) ch = CH_UP;
        else if (p < 72) ch = CH_DOWN;
        else if (p < 74) ch = CH_CR;
        else if (p < 75) ch = CH_NUL;
        else ch = 8'($urandom);
        if (p < 78) return mk(CMD_PUT, ch, 8'($urandom), 11'($urandom));
        if (p < 88) return mk(CMD_READ, ch, 8'($urandom),
                              ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                          : 11'($urandom_range(0, CELLS - 1)));
        if (p < 92) return mk(CMD_LOCK, ch, 8'($urandom),
                              ($urandom_range(0, 5) == 0) ? 11'($urandom)
                                                          : 11'($urandom_range(0, CELLS)));
        return mk(CMD_WRITE, 8'($urandom), 8'($urandom),
                  ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                              : 11'($urandom_range(0, CELLS - 1)));
    endfunction

    task automatic send_cmd(t_cmd_item it, bit has_exp, t_res_item exp_res);
        t_res_item r;
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        r = console_step(it);
        if (has_exp && r != exp_res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with shadow: exp %h got %h", exp_res, r);
        end
        pending_results.push_back(r);
        i_cmd = it;
        i_cmd_valid = 1'b1;
        @(posedge i_clk);
        while (o_cmd_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_cmd_valid = 1'b0;
    endtask

    // response side stall bursts
    initial begin
        i_res_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_res_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_res_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res_item e;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            results_seen++;
            if (o_res.scrolled) scrolls_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %p", o_res);
            end else begin
                e = pending_results.pop_front();
                if (o_res.cursor_pos !== e.cursor_pos || o_res.read_char !== e.read_char ||
                    o_res.read_attr !== e.read_attr || o_res.scrolled !== e.scrolled) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%h/%h/%b got %0d/%h/%h/%b",
                                 e.cursor_pos, e.read_char, e.read_attr, e.scrolled,
                                 o_res.cursor_pos, o_res.read_char, o_res.read_attr,
                                 o_res.scrolled);
                end
            end
        end
    end

    initial begin
        #400ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_row rows [$];
        t_res_item x;
        for (int i = 0; i < CELLS; i++) scr[i] = BLANK_CELL;
        cur = 0;
        lockp = 0;
        mismatches = 0;
        results_seen = 0;
        scrolls_seen = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_cmd_valid = 1'b0;
        i_cmd = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        x = '0;
        x.read_attr = BLANK_ATTR;
        rows.push_back('{mk(CMD_READ, 8'h00, 8'h00, 11'd0), 1'b1, x});
        x = '0;
        rows.push_back('{mk(CMD_READ, 8'hFF, 8'hFF, 11'h7FF), 1'b1, x});
        rows.push_back('{mk(CMD_PUT, CH_NUL, 8'hFF, 11'h7FF), 1'b1, x});
        rows.push_back('{mk(CMD_PUT, CH_LEFT, 8'h00, 11'd0), 1'b1, x});
        rows.push_back('{mk(CMD_PUT, CH_BS, 8'h00, 11'd0), 1'b1, x});
        rows.push_back('{mk(CMD_PUT, 8'hFF, 8'hFF, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_TAB, 8'h1E, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_CR, 8'h00, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_LEFT, 8'h00, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_RIGHT, 8'h00, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_LF, 8'h00, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_UP, 8'h00, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_DOWN, 8'h00, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_WRITE, 8'h41, 8'hAA, 11'd80), 1'b0, x});
        rows.push_back('{mk(CMD_WRITE, 8'hFF, 8'hFF, 11'h7FF), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_DOWN, 8'h00, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_PUT, CH_BS, 8'h00, 11'd0), 1'b0, x});
        rows.push_back('{mk(CMD_LOCK, 8'h00, 8'h00, 11'h7FF), 1'b0, x});
        rows.push_back('{mk(CMD_LOCK, 8'h00, 8'h00, 11'd2), 1'b0, x});
        rows.push_back('{mk(CMD_WRITE, 8'h5A, 8'h07, 11'd1999), 1'b0, x});
        rows.push_back('{mk(CMD_READ, 8'h00, 8'h00, 11'd1999), 1'b0, x});
        rows.push_back('{mk(CMD_READ, 8'h00, 8'h00, 11'd2000), 1'b0, x});
        foreach (rows[i]) send_cmd(rows[i].item, rows[i].has_exp, rows[i].exp);

        // drive to the screen end so scrolls happen early
        for (int i = 0; i < ROWS; i++) send_cmd(mk(CMD_PUT, CH_LF, 8'h00, 11'd0), 1'b0, x);
        send_cmd(mk(CMD_PUT, 8'h58, 8'h0C, 11'd0), 1'b0, x);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2)
                while (pending_results.size() != 0) @(negedge i_clk);
            if (n == N_RANDOM - 60) quiet = 1'b1;
            send_cmd(rand_cmd(), 1'b0, x);
        end

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (CELLS + 200) @(negedge i_clk);
        $display("covered %0d results, %0d with a scroll, over directed and random commands",
                 results_seen, scrolls_seen);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tcc_pkg.sv
hdl/tcc_screen_mem.sv
hdl/tcc_seq.sv
hdl/text_console_cursor_engine.sv
tb/sv/tb_text_console_cursor_engine.sv
